/* hw/rtl/b2da_pkg.sv */
// Shared constants and types for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int VALUE_WIDTH  = 64;
  localparam int MAX_DIGITS   = 20;

  localparam int VALUE_FIELD_W = 64;
  localparam int CHAR_W        = 6;
  localparam int COUNT_W       = 5;

  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef logic [3:0] bcd_digit_t;

  // Control from the sequencer to the BCD shift register.
  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } bcd_ctl_t;

endpackage

/* hw/rtl/b2da_if.sv */
// Handshake channels for the converter: binary input and digit output.
interface b2da_in_if;
  import b2da_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [VALUE_FIELD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
  import b2da_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  digit_char;
  logic [COUNT_W-1:0] digit_count;
  logic               last_digit;

  modport source (output valid, output digit_char, output digit_count, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input last_digit,
                  output ready);
endinterface

/* hw/rtl/b2da_bcd_shift.sv */
// BCD shift register with per-digit add-3 correction and a running digit count.
module b2da_bcd_shift (
  input  logic                              clk,
  input  logic                              rst,
  input  b2da_pkg::bcd_ctl_t                ctl,
  input  logic [b2da_pkg::DIGIT_IDX_W-1:0]  rd_idx,
  output b2da_pkg::bcd_digit_t              rd_digit,
  output logic [b2da_pkg::COUNT_W-1:0]      count
);
  import b2da_pkg::*;

  bcd_digit_t              digit      [MAX_DIGITS];
  bcd_digit_t              adj        [MAX_DIGITS];
  bcd_digit_t              digit_next [MAX_DIGITS];
  logic                    carry;
  logic [COUNT_W-1:0]      count_next;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit[i] >= 4'd5) ? digit[i] + 4'd3 : digit[i];
    end
    digit_next[0] = {adj[0][2:0], ctl.bit_in};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      digit_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
    carry = adj[MAX_DIGITS-1][3];
  end

  // Doubling plus one bit adds at most one digit; a carry out of the top
  // digit means the value no longer fits, so pin the count at full width.
  always_comb begin
    count_next = count;
    if (carry) begin
      count_next = COUNT_W'(MAX_DIGITS);
    end else if (count < COUNT_W'(MAX_DIGITS)) begin
      if (digit_next[count[DIGIT_IDX_W-1:0]] != 4'd0) begin
        count_next = count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit[i] <= 4'd0;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit[i] <= digit_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= COUNT_W'(1);
    end else if (ctl.shift) begin
      count <= count_next;
    end
  end

  assign rd_digit = digit[rd_idx];

endmodule

/* hw/rtl/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter: bit-serial double dabble, then digit output.
// Steps: accept the value, shift its VALUE_WIDTH (64) bits into the BCD register, then emit the digits.
// One item at a time: a new value is accepted only after the last digit of the previous one is taken.
// The BCD shift register takes one input bit per cycle; digits then leave one per cycle while dout.ready is high.
// Input ready is high only while the block holds no item.
// Reset (rst, synchronous) returns the sequencer to idle and drops any item in progress.
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  b2da_in_if.sink     din,
  b2da_out_if.source  dout
);
  import b2da_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t                   state;
  logic [VALUE_WIDTH-1:0]   vshift;
  logic [BIT_CNT_W-1:0]     bit_cnt;
  logic [COUNT_W-1:0]       k;

  bcd_ctl_t                 ctl;
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       pos;
  logic [DIGIT_IDX_W-1:0]   rd_idx;
  bcd_digit_t               rd_digit;
  logic                     in_acc;
  logic                     out_acc;
  logic                     last;

  assign in_acc  = din.valid && din.ready;
  assign out_acc = dout.valid && dout.ready;

  assign ctl.clear  = in_acc;
  assign ctl.shift  = (state == S_CONV);
  assign ctl.bit_in = vshift[VALUE_WIDTH-1];

  b2da_bcd_shift u_bcd (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .count    (count)
  );

  // Most significant digit first: position count-1 down to 0.
  assign pos    = count - COUNT_W'(1) - k;
  assign rd_idx = pos[DIGIT_IDX_W-1:0];
  assign last   = (k == count - COUNT_W'(1));

  assign din.ready        = (state == S_IDLE);
  assign dout.valid       = (state == S_EMIT);
  assign dout.digit_char  = ASCII_ZERO + {2'b00, rd_digit};
  assign dout.digit_count = count;
  assign dout.last_digit  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
      k       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            vshift  <= din.value[VALUE_WIDTH-1:0];
            bit_cnt <= BIT_CNT_W'(VALUE_WIDTH - 1);
            k       <= '0;
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          vshift  <= {vshift[VALUE_WIDTH-2:0], 1'b0};
          bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          if (bit_cnt == '0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              k <= k + COUNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/b2da_check.sv */
// Port-level checks for the converter, bound to the top level.
module b2da_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [b2da_pkg::CHAR_W-1:0]  digit_char,
  input logic [b2da_pkg::COUNT_W-1:0] digit_count,
  input logic                         last_digit
);
  import b2da_pkg::*;

  // No new item while digits are still leaving.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while digits pending");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("digit character out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_count != '0) && (digit_count <= COUNT_W'(MAX_DIGITS)))
    else $error("digit count out of range");

  // A run continues without gaps and keeps its count.
  a_run_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_digit |=> out_valid && $stable(digit_count))
    else $error("digit run broken");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
    else $error("stalled item changed");

endmodule

bind binary_to_decimal_ascii b2da_check u_b2da_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .digit_char  (dout.digit_char),
  .digit_count (dout.digit_count),
  .last_digit  (dout.last_digit)
);

/* dv/tb_top.sv */
// Self-checking testbench for the binary to decimal ASCII converter.
module tb_top;
  import b2da_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] cnt;
    logic               last;
  } digit_rec_t;

  class digit_scoreboard;
    localparam int RADIX = 10;

    digit_rec_t pending_digits[$];
    int         errors;
    int         values_seen;
    int         digits_checked;
    int         full_width_runs;

    function logic [VALUE_FIELD_W-1:0] width_mask();
      return {VALUE_FIELD_W{1'b1}} >> (VALUE_FIELD_W - VALUE_WIDTH);
    endfunction

    // Split an accepted value into its expected digit stream.
    function void note_value(logic [VALUE_FIELD_W-1:0] raw);
      logic [VALUE_FIELD_W-1:0] rest;
      bcd_digit_t               dig[$];
      digit_rec_t               rec;
      int                       lim;
      rest = raw & width_mask();
      lim  = (MAX_DIGITS > 20) ? 20 : (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
      do begin
        dig.push_front(bcd_digit_t'(rest % RADIX));
        rest = rest / RADIX;
      end while (rest != 0 && dig.size() < lim);
      for (int k = 0; k < dig.size(); k++) begin
        rec.ch   = ASCII_ZERO + CHAR_W'(dig[k]);
        rec.cnt  = COUNT_W'(dig.size());
        rec.last = (k == dig.size() - 1);
        pending_digits.push_back(rec);
      end
      values_seen++;
    endfunction

    function void check_digit(digit_rec_t got);
      digit_rec_t want;
      if (pending_digits.size() == 0) begin
        $error("digit with nothing expected: digit_char %0d digit_count %0d last_digit %0d",
               got.ch, got.cnt, got.last);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      digits_checked++;
      if (got.ch !== want.ch) begin
        $error("digit_char expected %0d actual %0d", want.ch, got.ch);
        errors++;
      end
      if (got.cnt !== want.cnt) begin
        $error("digit_count expected %0d actual %0d", want.cnt, got.cnt);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_digit expected %0d actual %0d", want.last, got.last);
        errors++;
      end
      if (want.last && want.cnt == MAX_DIGITS) full_width_runs++;
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_PER_PHASE = 95;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;

  digit_scoreboard board = new();

  b2da_in_if  din ();
  b2da_out_if dout ();

  binary_to_decimal_ascii u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din.sink),
    .dout (dout.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Output side: check what was accepted at this edge, then choose next ready.
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready)
      board.check_digit('{dout.digit_char, dout.digit_count, dout.last_digit});
    dout.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d digits outstanding",
               quiet_cycles, board.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_FIELD_W-1:0] v);
    // Hold valid low for a random gap, scrambling the payload meanwhile.
    while ($urandom_range(99) < send_idle_pct) begin
      din.valid <= 1'b0;
      din.value <= {$urandom, $urandom};
      @(posedge clk);
    end
    din.valid <= 1'b1;
    din.value <= v;
    do @(posedge clk); while (!din.ready);
    board.note_value(v);
  endtask

  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    logic [VALUE_FIELD_W-1:0] p;
    int                       nbits;
    int                       k;
    case ($urandom_range(3))
      0: pick_value = {$urandom, $urandom};
      1: begin
        nbits = $urandom_range(1, VALUE_FIELD_W);
        pick_value = {$urandom, $urandom} >> (VALUE_FIELD_W - nbits);
      end
      2: begin
        // Land on or next to a power of ten, where the digit count changes.
        p = VALUE_FIELD_W'(1);
        k = $urandom_range(19);
        repeat (k) p = p * VALUE_FIELD_W'(10);
        pick_value = p + VALUE_FIELD_W'($urandom_range(2)) - VALUE_FIELD_W'(1);
      end
      default: pick_value = VALUE_FIELD_W'($urandom_range(999));
    endcase
  endfunction

  task automatic run_phase(input int s_pct, input int r_pct, input int n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_value(pick_value());
  endtask

  logic [VALUE_FIELD_W-1:0] directed_values[] = '{
    64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd255,
    64'd4294967295, 64'd4294967296,
    64'd999999999999999999, 64'd1000000000000000000,
    64'd9999999999999999999, 64'd10000000000000000000,
    64'd9223372036854775808, 64'd12345678901234567890,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
  };

  initial begin
    rst           <= 1'b1;
    din.valid     <= 1'b0;
    din.value     <= '0;
    send_idle_pct = 18;
    recv_idle_pct = 71;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_values[i]) send_value(directed_values[i]);
    run_phase(18, 71, RANDOM_PER_PHASE);
    run_phase(71, 18, RANDOM_PER_PHASE);
    run_phase(0, 0, RANDOM_PER_PHASE);
    din.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d values into %0d digits, %0d of them full-width runs",
             board.values_seen, board.digits_checked, board.full_width_runs);
    $display("idle mixes: sender-light/receiver-heavy, the reverse, and back to back");
    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
